// ----- rtl/tqtp_pkg.sv -----
// Shared types and codes for the two-period timeout queue.
package tqtp_pkg;

    localparam int SLOT_W = 4;
    localparam int TICK_W = 64;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_TIMER = 2'd1,
        KIND_SCHED = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EV_EXPIRED = 2'd0,
        EV_ONESHOT = 2'd1,
        EV_ELAPSED = 2'd2,
        EV_EMPTY   = 2'd3
    } t_event_res;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_POP    = 2'd3
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_INS,
        ST_CHECK,
        ST_FLUSH,
        ST_ADVANCE,
        ST_EXPIRE,
        ST_SCHED
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] duration;
        logic [TICK_W-1:0] timer_value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [SLOT_W-1:0] expired_slot;
        logic [TICK_W-1:0] value;
        logic              last;
    } t_out_beat;

    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] end_t;
    } t_entry;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] end_t;
    } t_list_op;

endpackage

// ----- rtl/tqtp_cell.sv -----
// One list cell: holds one sorted entry and trades it with its neighbors.
module tqtp_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tqtp_pkg::t_list_op i_op,
    input  tqtp_pkg::t_entry  i_left,
    input  logic              i_left_lt,
    input  tqtp_pkg::t_entry  i_right,
    input  logic              i_hit,
    output tqtp_pkg::t_entry  o_entry,
    output logic              o_lt,
    output logic              o_hit
);
    import tqtp_pkg::*;

    logic              r_vld;
    logic [SLOT_W-1:0] r_slot;
    logic [TICK_W-1:0] r_end;
    t_entry            n_entry;
    logic              hit_here;

    assign o_entry  = '{vld: r_vld, slot: r_slot, end_t: r_end};
    assign o_lt     = r_vld && (r_end < i_op.end_t);
    assign hit_here = i_hit || (r_vld && (r_slot == i_op.slot));
    assign o_hit    = hit_here;

    always_comb begin
        n_entry = o_entry;
        case (i_op.cmd)
            CMD_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_entry = '{vld: 1'b1, slot: i_op.slot, end_t: i_op.end_t};
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit_here) begin
                    n_entry = i_right;
                end
            end
            CMD_POP:  n_entry = i_right;
            default:  n_entry = o_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_entry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_entry.slot;
        r_end  <= n_entry.end_t;
    end

endmodule

// ----- rtl/tqtp_list.sv -----
// Row of cells forming one end-time sorted list.
module tqtp_list #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tqtp_pkg::t_list_op i_op,
    output tqtp_pkg::t_entry   o_head
);
    import tqtp_pkg::*;

    t_entry w_ent [NUM_SLOTS];
    logic   w_lt  [NUM_SLOTS];
    logic   w_hit [NUM_SLOTS+1];

    assign w_hit[0] = 1'b0;
    assign o_head   = w_ent[0];

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_lt;
        if (g == 0) begin : g_first
            assign left_e  = '0;
            assign left_lt = 1'b1;
        end else begin : g_mid
            assign left_e  = w_ent[g-1];
            assign left_lt = w_lt[g-1];
        end
        if (g == NUM_SLOTS - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = w_ent[g+1];
        end
        tqtp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (i_op),
            .i_left    (left_e),
            .i_left_lt (left_lt),
            .i_right   (right_e),
            .i_hit     (w_hit[g]),
            .o_entry   (w_ent[g]),
            .o_lt      (w_lt[g]),
            .o_hit     (w_hit[g+1])
        );
    end

endmodule

// ----- rtl/timeout_queue_two_period.sv -----
// Top level: two-period sorted timeout queue with control sequencer.
// Set: remove pass in idle, then insert pass (ST_SET_INS); no result.
// Timer event: on a wrap, flush the current list and flip the period; advance now,
// expire each due slot, then send the elapsed beat; beats wait on a stalled output.
// Schedule: one result beat, held back while the output stalls.
// Throughput: one item in flight; the next is taken in idle, after the last beat, if any.
// Reset (synchronous, active low) empties both lists at once via the cell valid bits.
module timeout_queue_two_period #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tqtp_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tqtp_pkg::t_out_beat o_out
);
    import tqtp_pkg::*;

    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_now, n_now;
    logic              r_period, n_period;
    logic [TICK_W-1:0] r_last_prog, n_last_prog;
    logic [TICK_W-1:0] r_el, n_el;
    logic [SLOT_W-1:0] r_new_slot, n_new_slot;
    logic [TICK_W-1:0] r_new_end, n_new_end;
    logic              r_new_per, n_new_per;
    logic              r_ovalid, n_ovalid;
    t_out_beat         r_out, n_out;

    t_list_op          list_op [2];
    t_entry            head    [2];
    t_entry            cur_head;
    t_entry            oth_head;
    logic              emit_ok;
    logic              in_acc;

    // One list per period; the current list is picked by the period bit.
    for (genvar l = 0; l < 2; l++) begin : g_list
        tqtp_list #(.NUM_SLOTS(NUM_SLOTS)) u_list (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (list_op[l]),
            .o_head  (head[l])
        );
    end

    assign cur_head    = head[r_period];
    assign oth_head    = head[~r_period];
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    // Load a new beat when the output register is empty or being drained.
    assign emit_ok     = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_period    = r_period;
        n_last_prog = r_last_prog;
        n_el        = r_el;
        n_new_slot  = r_new_slot;
        n_new_end   = r_new_end;
        n_new_per   = r_new_per;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_out       = r_out;
        for (int l = 0; l < 2; l++) begin
            list_op[l] = '{cmd: CMD_HOLD, slot: r_new_slot, end_t: r_new_end};
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        KIND_SET: begin
                            if (32'(i_in.slot) < NUM_SLOTS) begin
                                // Drop any old listing of the slot from either list.
                                for (int l = 0; l < 2; l++) begin
                                    list_op[l].cmd  = CMD_REMOVE;
                                    list_op[l].slot = i_in.slot;
                                end
                                n_new_slot = i_in.slot;
                                n_new_end  = r_now + i_in.duration;
                                n_new_per  = r_period ^ (i_in.duration > ~r_now);
                                n_state    = ST_SET_INS;
                            end
                        end
                        KIND_TIMER: begin
                            n_el    = (r_last_prog > i_in.timer_value)
                                      ? (r_last_prog - i_in.timer_value)
                                      : TICK_W'(1);
                            n_state = ST_CHECK;
                        end
                        KIND_SCHED: n_state = ST_SCHED;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SET_INS: begin
                list_op[r_new_per].cmd = CMD_INSERT;
                n_state = ST_IDLE;
            end
            ST_CHECK: begin
                n_state = (r_el > ~r_now) ? ST_FLUSH : ST_ADVANCE;
            end
            ST_FLUSH: begin
                // Expire the whole current list, then flip the period.
                if (cur_head.vld) begin
                    if (emit_ok) begin
                        list_op[r_period].cmd = CMD_POP;
                        n_ovalid = 1'b1;
                        n_out    = '{event_res: EV_EXPIRED, expired_slot: cur_head.slot,
                                     value: '0, last: 1'b0};
                    end
                end else begin
                    n_period = ~r_period;
                    n_state  = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                n_now   = r_now + r_el;
                n_state = ST_EXPIRE;
            end
            ST_EXPIRE: begin
                if (emit_ok) begin
                    n_ovalid = 1'b1;
                    if (cur_head.vld && (cur_head.end_t <= r_now)) begin
                        list_op[r_period].cmd = CMD_POP;
                        n_out = '{event_res: EV_EXPIRED, expired_slot: cur_head.slot,
                                  value: '0, last: 1'b0};
                    end else begin
                        n_out   = '{event_res: EV_ELAPSED, expired_slot: '0,
                                    value: r_el, last: 1'b1};
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCHED: begin
                if (emit_ok) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                    if (cur_head.vld) begin
                        n_last_prog = cur_head.end_t - r_now;
                        n_out = '{event_res: EV_ONESHOT, expired_slot: '0,
                                  value: cur_head.end_t - r_now, last: 1'b1};
                    end else if (oth_head.vld) begin
                        n_last_prog = oth_head.end_t - r_now;
                        n_out = '{event_res: EV_ONESHOT, expired_slot: '0,
                                  value: oth_head.end_t - r_now, last: 1'b1};
                    end else begin
                        n_out = '{event_res: EV_EMPTY, expired_slot: '0,
                                  value: '0, last: 1'b1};
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_period    <= 1'b0;
            r_last_prog <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_period    <= n_period;
            r_last_prog <= n_last_prog;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_el       <= n_el;
        r_new_slot <= n_new_slot;
        r_new_end  <= n_new_end;
        r_new_per  <= n_new_per;
        r_out      <= n_out;
    end

    a_elapsed_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.event_res == EV_ELAPSED) |-> r_out.last)
        else $error("elapsed beat not marked last");

    a_expiry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.event_res == EV_EXPIRED) |-> !r_out.last)
        else $error("expiry beat marked last");

    a_oneshot_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.event_res == EV_ONESHOT) |-> (r_last_prog == r_out.value))
        else $error("programmed duration not held");

    a_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPIRE && emit_ok && !(cur_head.vld && cur_head.end_t <= r_now))
        |=> o_in_ready)
        else $error("sequencer did not return to idle after elapsed beat");

endmodule

// ----- tb/tqtp_checker.sv -----
// Checker for the timeout queue: watches both channels, predicts results, compares them.
module tqtp_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tqtp_pkg::t_in_beat  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tqtp_pkg::t_out_beat i_out,
    output int                  o_fail_count,
    output int                  o_pending
);
    import tqtp_pkg::*;

    logic [63:0] now_t;
    logic        cur_period;
    logic [63:0] programmed;
    logic        listed [NUM_SLOTS];
    logic [63:0] end_at [NUM_SLOTS];
    logic        end_period [NUM_SLOTS];
    int          order [2][$];
    t_out_beat   result_fifo [$];

    // Drop slot s from list l.
    function automatic void unlist(input logic l, input int s);
        for (int i = 0; i < order[l].size(); i++) begin
            if (order[l][i] == s) begin
                order[l].delete(i);
                return;
            end
        end
    endfunction

    function automatic void push_result(input t_event_res ev, input int s,
                                        input logic [63:0] v, input logic lst);
        t_out_beat b;
        b.event_res    = ev;
        b.expired_slot = s[SLOT_W-1:0];
        b.value        = v;
        b.last         = lst;
        result_fifo.push_back(b);
    endfunction

    function automatic void expire_head(input logic l);
        int s;
        s = order[l].pop_front();
        listed[s] = 1'b0;
        push_result(EV_EXPIRED, s, '0, 1'b0);
    endfunction

    // Advance the model by one accepted input beat.
    function automatic void predict_queue(input t_in_beat b);
        int s;
        int pos;
        logic l;
        logic [63:0] el;
        case (t_kind'(b.kind))
            KIND_SET: begin
                s = int'(b.slot);
                if (s < NUM_SLOTS) begin
                    if (listed[s]) unlist(end_period[s], s);
                    listed[s]     = 1'b1;
                    end_at[s]     = now_t + b.duration;
                    end_period[s] = (b.duration > ~now_t) ? ~cur_period : cur_period;
                    l = end_period[s];
                    pos = 0;
                    while (pos < order[l].size() && end_at[order[l][pos]] < end_at[s])
                        pos++;
                    order[l].insert(pos, s);
                end
            end
            KIND_TIMER: begin
                el = (programmed > b.timer_value) ? programmed - b.timer_value : 64'd1;
                if (el > ~now_t) begin
                    while (order[cur_period].size() > 0) expire_head(cur_period);
                    cur_period = ~cur_period;
                end
                now_t = now_t + el;
                while (order[cur_period].size() > 0 &&
                       end_at[order[cur_period][0]] <= now_t)
                    expire_head(cur_period);
                push_result(EV_ELAPSED, 0, el, 1'b1);
            end
            KIND_SCHED: begin
                l = cur_period;
                if (order[l].size() == 0) l = ~l;
                if (order[l].size() == 0) begin
                    push_result(EV_EMPTY, 0, '0, 1'b1);
                end else begin
                    programmed = end_at[order[l][0]] - now_t;
                    push_result(EV_ONESHOT, 0, programmed, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    assign o_pending = result_fifo.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            now_t      <= '0;
            cur_period <= 1'b0;
            programmed <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) listed[i] = 1'b0;
            order[0].delete();
            order[1].delete();
            result_fifo.delete();
            o_fail_count <= 0;
        end else begin
            // Compare the output beat first: it belongs to an earlier input.
            if (i_out_valid && i_out_ready) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %p", $time, i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (i_out !== want) begin
                        $display("%0t: expected %p, actual %p", $time, want, i_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_queue(i_in);
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: drives stimulus into the timeout queue and reports the verdict.
module testbench;
    import tqtp_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        quiet_cycles;

    timeout_queue_two_period #(.NUM_SLOTS(NSLOT)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    tqtp_checker #(.NUM_SLOTS(NSLOT)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stall at random according to the current phase.
    initial out_ready = 1'b0;
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Present one beat and hold it until accepted; idle beforehand at random.
    task automatic send_beat(input t_kind k, input logic [3:0] s,
                             input logic [63:0] d, input logic [63:0] tv);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid          <= 1'b1;
        in_beat.kind      <= k;
        in_beat.slot      <= s;
        in_beat.duration  <= d;
        in_beat.timer_value <= tv;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Mostly small durations so expiries happen; sometimes huge ones to wrap.
    function automatic logic [63:0] pick_ticks();
        case ($urandom_range(9))
            0:       return {$urandom, $urandom};
            1:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(50);
            2:       return 64'd0;
            default: return 64'($urandom_range(300));
        endcase
    endfunction

    // Random item weighted toward well-formed set/schedule/timer cycles.
    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_beat(KIND_SET, 4'($urandom), pick_ticks(), {$urandom, $urandom});
        else if (r < 70)
            send_beat(KIND_SCHED, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        else if (r < 97)
            send_beat(KIND_TIMER, 4'($urandom), {$urandom, $urandom},
                      ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(200)));
        else
            send_beat(KIND_NONE, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    initial begin
        in_valid      = 1'b0;
        in_beat       = '0;
        i_rst_n       = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 83;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty schedule, timer with nothing programmed, field extremes.
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, '0);
        send_beat(KIND_NONE, 4'hF, '1, '1);
        send_beat(KIND_SET, 4'd0, 64'd10, '0);
        send_beat(KIND_SET, 4'd1, 64'd10, '0);     // tie: later insert goes first
        send_beat(KIND_SET, 4'hF, '1, '1);         // end wraps into the other list
        send_beat(KIND_SET, 4'd2, 64'd5, '0);
        send_beat(KIND_SET, 4'd2, 64'd20, '0);     // relist an already listed slot
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, 64'd0);    // elapsed equals the programmed value
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, '1);       // counter above programmed: minimum 1
        for (int i = 3; i < 14; i++) send_beat(KIND_SET, 4'(i), 64'(i * 7), '0);
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, '0);
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, '0);
        send_beat(KIND_SET, 4'd5, 64'hFFFF_FFFF_FFFF_FFF0, '0);
        send_beat(KIND_SCHED, 4'd0, '0, '0);
        send_beat(KIND_TIMER, 4'd0, '0, '0);       // elapsed equals the programmed value: no wrap flush

        // Hold off until every expected beat has drained.
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < 40; n++) begin
                send_random();
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/tqtp_pkg.sv
rtl/tqtp_cell.sv
rtl/tqtp_list.sv
rtl/timeout_queue_two_period.sv
tb/tqtp_checker.sv
tb/testbench.sv
